### hdl/qnpi_pkg.sv
// Shared constants, config register codes and stage payload types
// for the quad node permutation index pipeline. No dependencies.
package qnpi_pkg;

  // Highest polynomial order handled; larger settings saturate here
  localparam int MAX_ORDER  = 15;
  // Concentric layers of order >= 1 at MAX_ORDER
  localparam int NUM_LAYERS = (MAX_ORDER + 1) / 2;

  localparam int IDX_W      = 8;
  localparam int ORD_W      = 4;
  localparam int CNT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int LYR_W      = $clog2(NUM_LAYERS + 1);
  localparam int LOC_W      = $clog2(4 * MAX_ORDER);
  localparam int TOT_W      = 2 * (ORD_W + 1);

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_ORDER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_COUNT = 2'd2;

  // After layer compares
  typedef struct packed {
    logic [IDX_W-1:0]      j;
    logic [ORD_W-1:0]      p;
    logic [CNT_W-1:0]      rot;
    logic [CNT_W-1:0]      flip;
    logic                  oor;
    logic [NUM_LAYERS-1:0] hits;
  } s1_t;

  // After layer decode: layer-local index
  typedef struct packed {
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] offset;
    logic [LOC_W-1:0] k;
    logic [ORD_W-1:0] cur;
    logic [CNT_W-1:0] rot;
    logic [CNT_W-1:0] flip;
    logic             oor;
  } s2_t;

  // After corner / edge split
  typedef struct packed {
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] offset;
    logic             corner;
    logic [1:0]       c;
    logic [1:0]       e;
    logic [ORD_W-1:0] i;
    logic [ORD_W-1:0] n;
    logic             center;
    logic [CNT_W-1:0] rot;
    logic [CNT_W-1:0] flip;
    logic             oor;
  } s3_t;

endpackage

### hdl/quad_node_permutation_index.sv
// Top level: config registers and the four-stage node permutation pipeline.
// Depends on qnpi_pkg, qnpi_layer, qnpi_edge, qnpi_map.
//
//   channel | signals                                   | transfer when
//   --------+-------------------------------------------+---------------------
//   in      | in_valid, in_ready, in_node_index         | in_valid & in_ready
//   out     | out_valid, out_ready, out_permuted_index, | out_valid & out_ready
//           | out_out_of_range                          |
//   cfg     | cfg_wr_en, cfg_index, cfg_data            | cfg_wr_en
//
// An input transfer passes the stages in order to result valid: layer compare,
// layer decode, edge split, rotate/flip into the output register.
// One item per cycle with out_ready high; a stage holds while the next is full.
// A stall at the output backs up stage by stage; bubbles are squeezed out.
// Synchronous reset clears all stage valids and loads the config defaults.
module quad_node_permutation_index (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [qnpi_pkg::IDX_W-1:0]      in_node_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qnpi_pkg::IDX_W-1:0]      out_permuted_index,
  output logic                            out_out_of_range,
  input  logic                            cfg_wr_en,
  input  logic [qnpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qnpi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qnpi_pkg::*;

  logic [ORD_W-1:0] elem_order_r, elem_order_nxt;
  logic [CNT_W-1:0] flip_count_r, flip_count_nxt;
  logic [CNT_W-1:0] rotation_count_r, rotation_count_nxt;

  logic l2e_valid, l2e_ready;
  s2_t  l2e_data;
  logic e2m_valid, e2m_ready;
  s3_t  e2m_data;

  // Config write decode
  always_comb begin
    elem_order_nxt     = elem_order_r;
    flip_count_nxt     = flip_count_r;
    rotation_count_nxt = rotation_count_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ELEM_ORDER:     elem_order_nxt     = cfg_data[ORD_W-1:0];
        CFG_FLIP_COUNT:     flip_count_nxt     = cfg_data[CNT_W-1:0];
        CFG_ROTATION_COUNT: rotation_count_nxt = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_order_r     <= ORD_W'(1);
      flip_count_r     <= '0;
      rotation_count_r <= '0;
    end else begin
      elem_order_r     <= elem_order_nxt;
      flip_count_r     <= flip_count_nxt;
      rotation_count_r <= rotation_count_nxt;
    end
  end

  // Pipeline
  qnpi_layer u_layer (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_node_index  (in_node_index),
    .elem_order     (elem_order_r),
    .rotation_count (rotation_count_r),
    .flip_count     (flip_count_r),
    .out_valid      (l2e_valid),
    .out_ready      (l2e_ready),
    .out_data       (l2e_data)
  );

  qnpi_edge u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (l2e_valid),
    .in_ready  (l2e_ready),
    .in_data   (l2e_data),
    .out_valid (e2m_valid),
    .out_ready (e2m_ready),
    .out_data  (e2m_data)
  );

  qnpi_map u_map (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (e2m_valid),
    .in_ready           (e2m_ready),
    .in_data            (e2m_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_permuted_index (out_permuted_index),
    .out_out_of_range   (out_out_of_range)
  );

endmodule

### hdl/qnpi_layer.sv
// Layer locate stages: boundary compares, then layer decode and local index.
// Depends on qnpi_pkg.
module qnpi_layer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qnpi_pkg::IDX_W-1:0]    in_node_index,
  input  logic [qnpi_pkg::ORD_W-1:0]    elem_order,
  input  logic [qnpi_pkg::CNT_W-1:0]    rotation_count,
  input  logic [qnpi_pkg::CNT_W-1:0]    flip_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qnpi_pkg::s2_t                 out_data
);
  import qnpi_pkg::*;

  logic            s1_valid_r, s1_valid_nxt;
  s1_t             s1_r, s1_nxt;
  logic            s2_valid_r, s2_valid_nxt;
  s2_t             s2_r, s2_nxt;
  logic            s1_ready, s2_ready;

  logic [ORD_W-1:0] p_sat;
  logic [ORD_W:0]   p_inc;
  logic [TOT_W-1:0] total;

  // Stage handshakes
  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: saturate order, range check, compare against each layer end
  always_comb begin
    logic [ORD_W:0]   diff;
    logic [TOT_W-1:0] bnd;
    logic             lyr_ok;
    p_sat = (int'(elem_order) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : elem_order;
    p_inc = {1'b0, p_sat} + (ORD_W+1)'(1);
    total = TOT_W'(p_inc) * TOT_W'(p_inc);
    s1_nxt.j    = in_node_index;
    s1_nxt.p    = p_sat;
    s1_nxt.rot  = rotation_count;
    s1_nxt.flip = flip_count;
    s1_nxt.oor  = (TOT_W'(in_node_index) >= total);
    for (int l = 0; l < NUM_LAYERS; l++) begin
      // layer l ends at 4*(l+1)*(P-l)
      diff   = {1'b0, p_sat} - (ORD_W+1)'(l);
      bnd    = (TOT_W'(diff) * TOT_W'(l + 1)) << 2;
      lyr_ok = ({1'b0, p_sat} >= (ORD_W+1)'(2 * l + 1));
      s1_nxt.hits[l] = lyr_ok && (TOT_W'(in_node_index) >= bnd);
    end
  end

  assign s1_valid_nxt = s1_ready ? in_valid : s1_valid_r;

  // Stage 2: layer number, layer order, layer offset, local index
  always_comb begin
    logic [LYR_W-1:0]   lyr;
    logic [ORD_W:0]     cur_w;
    logic [ORD_W:0]     span;
    logic [TOT_W:0]     off_w;
    logic [IDX_W-1:0]   k_w;
    lyr   = LYR_W'($countones(s1_r.hits));
    cur_w = {1'b0, s1_r.p} - ((ORD_W+1)'(lyr) << 1);
    span  = {1'b0, s1_r.p} + (ORD_W+1)'(1) - (ORD_W+1)'(lyr);
    off_w = (( TOT_W+1)'(span) * (TOT_W+1)'(lyr)) << 2;
    k_w   = s1_r.j - off_w[IDX_W-1:0];
    s2_nxt.j      = s1_r.j;
    s2_nxt.offset = off_w[IDX_W-1:0];
    s2_nxt.k      = k_w[LOC_W-1:0];
    s2_nxt.cur    = cur_w[ORD_W-1:0];
    s2_nxt.rot    = s1_r.rot;
    s2_nxt.flip   = s1_r.flip;
    s2_nxt.oor    = s1_r.oor;
  end

  assign s2_valid_nxt = s2_ready ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_r;

endmodule

### hdl/qnpi_edge.sv
// Corner / edge split stage: edge number and position along the edge.
// Depends on qnpi_pkg.
module qnpi_edge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qnpi_pkg::s2_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qnpi_pkg::s3_t out_data
);
  import qnpi_pkg::*;

  logic valid_r, valid_nxt;
  s3_t  data_r, data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Edge number by three compares against multiples of the edge length
  always_comb begin
    logic [ORD_W-1:0] n;
    logic [LOC_W-1:0] m;
    logic [LOC_W-1:0] n1, n2, n3, en, i_w;
    logic             ge1, ge2, ge3;
    logic [1:0]       e;
    n   = in_data.cur - ORD_W'(1);
    m   = in_data.k - LOC_W'(4);
    n1  = LOC_W'(n);
    n2  = n1 << 1;
    n3  = n2 + n1;
    ge1 = (m >= n1);
    ge2 = (m >= n2);
    ge3 = (m >= n3);
    e   = 2'(ge1) + 2'(ge2) + 2'(ge3);
    case (e)
      2'd0:    en = '0;
      2'd1:    en = n1;
      2'd2:    en = n2;
      default: en = n3;
    endcase
    i_w = m - en;
    data_nxt.j      = in_data.j;
    data_nxt.offset = in_data.offset;
    data_nxt.corner = (in_data.k < LOC_W'(4));
    data_nxt.c      = in_data.k[1:0];
    data_nxt.e      = e;
    data_nxt.i      = i_w[ORD_W-1:0];
    data_nxt.n      = n;
    data_nxt.center = (in_data.cur == '0);
    data_nxt.rot    = in_data.rot;
    data_nxt.flip   = in_data.flip;
    data_nxt.oor    = in_data.oor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hdl/qnpi_map.sv
// Rotate / flip stage and output register.
// Depends on qnpi_pkg.
module qnpi_map (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  qnpi_pkg::s3_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [qnpi_pkg::IDX_W-1:0] out_permuted_index,
  output logic                       out_out_of_range
);
  import qnpi_pkg::*;

  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] index_r, index_nxt;
  logic             oor_r;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // Rotations shift corner/edge numbers down by one each; two flips cancel
  always_comb begin
    logic             fl;
    logic [1:0]       c_r, c_f, e_r, e_f;
    logic [ORD_W-1:0] i_f;
    logic [5:0]       edge_base;
    logic [IDX_W-1:0] idx_corner, idx_edge;
    fl        = in_data.flip[0];
    c_r       = in_data.c - in_data.rot;
    c_f       = fl ? (c_r ^ 2'b01) : c_r;
    e_r       = in_data.e - in_data.rot;
    e_f       = fl ? (2'd0 - e_r) : e_r;
    i_f       = fl ? (in_data.n - ORD_W'(1) - in_data.i) : in_data.i;
    edge_base = 6'(e_f) * 6'(in_data.n);
    idx_corner = in_data.offset + IDX_W'(c_f);
    idx_edge   = in_data.offset + IDX_W'(4) + IDX_W'(edge_base) + IDX_W'(i_f);
    if (in_data.oor) begin
      index_nxt = '0;
    end else if (in_data.center) begin
      index_nxt = in_data.j;
    end else if (in_data.corner) begin
      index_nxt = idx_corner;
    end else begin
      index_nxt = idx_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      index_r <= index_nxt;
      oor_r   <= in_data.oor;
    end
  end

  assign out_valid          = valid_r;
  assign out_permuted_index = index_r;
  assign out_out_of_range   = oor_r;

endmodule

### hdl/qnpi_checker.sv
// Port-level checks for quad_node_permutation_index, bound to the top level.
// Depends on qnpi_pkg.
module qnpi_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [qnpi_pkg::IDX_W-1:0] out_permuted_index,
  input logic                       out_out_of_range
);
  import qnpi_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_permuted_index)
      && $stable(out_out_of_range))
    else $error("result changed while stalled");

  // Out-of-range results carry index zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_permuted_index == '0)
    else $error("out-of-range result with nonzero index");

  // An empty output stage means the whole pipe can take input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quad_node_permutation_index qnpi_checker u_qnpi_checker (.*);
